// ===== sv/slfg_pkg.sv =====
// Shared constants, register codes and the queue status struct of the scanline run fill generator.
`default_nettype none

package slfg_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COLOR_BITS      = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSPARENT_KEY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X          = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y          = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT     = 3'd4;

    // Status of the command queue as seen by the top level and the back part.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== sv/slfg_front.sv =====
// Front part: configuration registers, run tracking and forming of fill commands per pixel.
`default_nettype none

module slfg_front
    import slfg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int RES_W      = 3 * COORD_BITS + 1 + COLOR_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_accept,
    input  wire logic [COLOR_BITS-1:0]    i_pixel_color,
    output logic                          o_push,
    output logic [2*RES_W:0]              o_record
);

    localparam int LW = COORD_BITS + 1;
    localparam logic [LW-1:0] COUNT_MAX = LW'(1) << COORD_BITS;
    localparam logic [LW-1:0] ONE_L     = LW'(1);

    logic [COLOR_BITS-1:0] r_key;
    logic [COORD_BITS-1:0] r_clip_x;
    logic [COORD_BITS-1:0] r_clip_y;
    logic [LW-1:0]         r_clip_w;
    logic [LW-1:0]         r_clip_h;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_start, n_start;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic                  r_open, n_open;

    logic [LW-1:0]         eff_w, eff_h;
    logic                  close_a, start_new, cur_open, row_end, close_b;
    logic [COORD_BITS-1:0] cur_start;
    logic [COLOR_BITS-1:0] cur_color;
    logic [RES_W-1:0]      res_a, res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_clip_x <= '0;
            r_clip_y <= '0;
            r_clip_w <= ONE_L;
            r_clip_h <= ONE_L;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRANSPARENT_KEY: r_key    <= i_cfg_data[COLOR_BITS-1:0];
                CFG_CLIP_X:          r_clip_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CLIP_Y:          r_clip_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_CLIP_WIDTH:      r_clip_w <= i_cfg_data[LW-1:0];
                CFG_CLIP_HEIGHT:     r_clip_h <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // A zero or oversize size means the full coordinate range.
        eff_w = r_clip_w;
        if (r_clip_w == '0 || (r_clip_w[COORD_BITS] && r_clip_w[COORD_BITS-1:0] != '0)) begin
            eff_w = COUNT_MAX;
        end
        eff_h = r_clip_h;
        if (r_clip_h == '0 || (r_clip_h[COORD_BITS] && r_clip_h[COORD_BITS-1:0] != '0)) begin
            eff_h = COUNT_MAX;
        end

        close_a   = r_open && (i_pixel_color != r_color);
        start_new = (!r_open || close_a) && (i_pixel_color != r_key);
        cur_open  = (r_open && !close_a) || start_new;
        cur_start = start_new ? r_col : r_start;
        cur_color = start_new ? i_pixel_color : r_color;
        row_end   = {1'b0, r_col} >= (eff_w - ONE_L);
        close_b   = row_end && cur_open;

        res_a = {r_clip_x + r_start, r_clip_y + r_row,
                 {1'b0, r_col} - {1'b0, r_start}, r_color};
        res_b = {r_clip_x + cur_start, r_clip_y + r_row,
                 {1'b0, r_col} + ONE_L - {1'b0, cur_start}, cur_color};

        o_push = i_accept && (close_a || close_b);
        // Record: second-result flag, second result, first result.
        if (close_a) begin
            o_record = {close_b, res_b, res_a};
        end else begin
            o_record = {1'b0, res_b, res_b};
        end

        n_start = cur_start;
        n_color = cur_color;
        n_open  = cur_open && !row_end;
        n_row   = r_row;
        if (row_end) begin
            n_col = '0;
            if ({1'b0, r_row} >= (eff_h - ONE_L)) begin
                n_row = '0;
            end else begin
                n_row = r_row + COORD_BITS'(1);
            end
        end else begin
            n_col = r_col + COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_start <= '0;
            r_color <= '0;
            r_open  <= 1'b0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_start <= n_start;
            r_color <= n_color;
            r_open  <= n_open;
        end
    end

endmodule

`default_nettype wire

// ===== sv/slfg_queue.sv =====
// Short queue of command records between the front and back parts.
`default_nettype none

module slfg_queue
    import slfg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output t_q_stat               o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_data       = mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== sv/slfg_back.sv =====
// Back part: output register that hands out the one or two commands of each record.
`default_nettype none

module slfg_back
    import slfg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int RES_W      = 3 * COORD_BITS + 1 + COLOR_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_q_stat            i_q_stat,
    input  wire logic [2*RES_W:0]   i_q_data,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [COORD_BITS-1:0]   o_run_x,
    output logic [COORD_BITS-1:0]   o_run_y,
    output logic [COORD_BITS:0]     o_run_length,
    output logic [COLOR_BITS-1:0]   o_run_color,
    output logic                    o_last_in_item
);

    logic [2*RES_W:0] r_rec;
    logic             r_valid, n_valid;
    logic             r_phase, n_phase;
    logic             two, finish, advance, load;
    logic [RES_W-1:0] cur;

    always_comb begin
        two     = r_rec[2*RES_W];
        finish  = i_pop && r_valid && (r_phase || !two);
        advance = i_pop && r_valid && !r_phase && two;
        load    = (!r_valid || finish) && !i_q_stat.empty;
        n_valid = load ? 1'b1 : (finish ? 1'b0 : r_valid);
        n_phase = (load || finish) ? 1'b0 : (advance ? 1'b1 : r_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_data;
        end
    end

    assign o_q_pop = load;
    assign cur     = r_phase ? r_rec[2*RES_W-1:RES_W] : r_rec[RES_W-1:0];
    assign o_empty = !r_valid;
    assign {o_run_x, o_run_y, o_run_length, o_run_color} = cur;
    assign o_last_in_item = r_phase || !two;

endmodule

`default_nettype wire

// ===== sv/scanline_run_fill_generator_top.sv =====
// Top level of the scanline run fill generator: front part, command queue and back part.
//
// Pixels of a clipped rectangle enter in raster order through a queue-like port:
// a word is taken at a rising edge with push high and full low. Fill commands
// leave through a second queue-like port: while empty is low the oldest command
// is on the run ports, and it is taken at an edge with pop high.
// Each pixel gives no command, one, or two (a colour change and the end of the
// row in the same pixel); last_in_item marks the final command of a pixel.
// Configuration words are written through their own valid/ready channel, which
// is always ready; writes are meant for idle periods only.
// Throughput is one pixel per cycle while full is low; the run decision in the
// front part is combinational. A pixel's commands pass through the queue and the
// output register before they reach the run ports; a pixel with two commands holds
// the output port until both have been taken.
// When the receiver stalls, commands collect in the queue and full rises only
// once the queue is full and the output register is occupied.
// Synchronous reset clears run state and counters, empties the queue and the output
// register, and loads the configuration registers with their reset values.
`default_nettype none

module scanline_run_fill_generator_top
    import slfg_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [COLOR_BITS-1:0]    i_pixel_color,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [COORD_BITS-1:0]         o_run_x,
    output logic [COORD_BITS-1:0]         o_run_y,
    output logic [COORD_BITS:0]           o_run_length,
    output logic [COLOR_BITS-1:0]         o_run_color,
    output logic                          o_last_in_item
);

    // One command: x, y, length and colour.
    localparam int RES_W = 3 * COORD_BITS + 1 + COLOR_BITS;
    // One record: a second-command flag followed by two commands.
    localparam int REC_W = 2 * RES_W + 1;

    t_q_stat          q_stat;
    logic             q_push, q_pop;
    logic [REC_W-1:0] q_wr_data, q_rd_data;
    logic             accept;

    // Configuration registers take a word in every cycle.
    assign o_cfg_ready = 1'b1;
    assign full        = q_stat.full;
    assign accept      = push && !q_stat.full;

    slfg_front #(
        .COORD_BITS (COORD_BITS),
        .RES_W      (RES_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pixel_color (i_pixel_color),
        .o_push        (q_push),
        .o_record      (q_wr_data)
    );

    slfg_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_stat  (q_stat)
    );

    slfg_back #(
        .COORD_BITS (COORD_BITS),
        .RES_W      (RES_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_q_data       (q_rd_data),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_run_x        (o_run_x),
        .o_run_y        (o_run_y),
        .o_run_length   (o_run_length),
        .o_run_color    (o_run_color),
        .o_last_in_item (o_last_in_item)
    );

endmodule

`default_nettype wire

// ===== sv/slfg_checker.sv =====
// Port-level checks of the scanline run fill generator and their bind to the top level.
`default_nettype none

module slfg_checker
    import slfg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  push,
    input wire logic                  full,
    input wire logic                  empty,
    input wire logic                  pop,
    input wire logic                  o_cfg_ready,
    input wire logic [COORD_BITS-1:0] o_run_x,
    input wire logic [COORD_BITS:0]   o_run_length
);

    // Reset leaves no command waiting and room for pixels.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not cleared by reset");

    // A fill command never has zero length.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_run_length != '0)
        else $error("zero-length run command");

    // Directly after reset, with no pixel pushed, no command comes out.
    a_no_invented: assert property (@(posedge i_clk)
        !i_rst_n ##1 !push |=> empty)
        else $error("command appeared without a pixel");

    // A stalled command holds its place.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_run_x) && $stable(o_run_length))
        else $error("stalled command changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind scanline_run_fill_generator_top slfg_checker #(.COORD_BITS(COORD_BITS)) u_slfg_checker (.*);

`default_nettype wire
